FILE: design/rpc_pkg.sv
// Package for the rigid pose composition core: word types, register indexes,
// pipeline depths and the fixed-point rounding helper. No dependencies.
package rpc_pkg;

  typedef logic signed [31:0] word_t;

  localparam int NUM_REGS   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 30;
  // squares, sum, root steps, numerator, divide steps, final clamp
  localparam int NORM_LAT   = 1 + 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int COMP_LAT   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_W = 3'd6;

  localparam logic signed [31:0] Q_ONE  = 32'sd268435456;
  localparam logic signed [63:0] Q_ONE2 = 64'sd72057594037927936;

  // Shift right by 28, rounding half away from zero, with a single add.
  function automatic logic signed [63:0] rnd28(input logic signed [63:0] v);
    logic signed [63:0] h;
    h = v[63] ? 64'sd134217727 : 64'sd134217728;
    return (v + h) >>> 28;
  endfunction

endpackage

FILE: design/rpc_delay.sv
// Enable-gated delay line that keeps side data aligned with the pipeline.
// Depends on nothing.
module rpc_delay #(
  parameter int Width = 32,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [Width-1:0] d,
  output logic [Width-1:0] q
);

  logic [Width-1:0] tap_r [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < Depth; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[Depth-1];

endmodule

FILE: design/rpc_qnorm.sv
// Pipelined quaternion normalizer: squares, saturating sum, bit-per-stage
// square root and restoring divide. Depends on rpc_pkg.
module rpc_qnorm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] in_q [4],
  output logic               out_valid,
  output logic               out_zero,
  output logic signed [31:0] out_q [4]
);

  localparam int SqSteps = rpc_pkg::SQRT_STEPS;
  localparam int DvSteps = rpc_pkg::DIV_STEPS;
  localparam logic [28:0] MagOne = 29'h1000_0000;

  // stage A: magnitudes and squares
  logic        a_v_r;
  logic [3:0]  a_sg_r;
  logic [31:0] a_m_r [4];
  logic [63:0] a_sq_r [4];
  // stage B: sum of squares
  logic        b_v_r;
  logic [3:0]  b_sg_r;
  logic        b_zero_r;
  logic [31:0] b_m_r [4];
  logic [63:0] b_s_r;
  // root steps
  logic        sq_v_r    [SqSteps];
  logic [63:0] sq_n_r    [SqSteps];
  logic [63:0] sq_r_r    [SqSteps];
  logic [31:0] sq_m_r    [SqSteps][4];
  logic [3:0]  sq_sg_r   [SqSteps];
  logic        sq_zero_r [SqSteps];
  // numerator stage
  logic        nm_v_r;
  logic [59:0] nm_num_r [4];
  logic [31:0] nm_n_r;
  logic [3:0]  nm_sg_r;
  logic        nm_zero_r;
  // divide steps
  logic        dv_v_r    [DvSteps];
  logic [59:0] dv_rem_r  [DvSteps][4];
  logic [28:0] dv_q_r    [DvSteps][4];
  logic [3:0]  dv_sat_r  [DvSteps];
  logic [31:0] dv_n_r    [DvSteps];
  logic [3:0]  dv_sg_r   [DvSteps];
  logic        dv_zero_r [DvSteps];
  // final
  logic               f_v_r;
  logic               f_zero_r;
  logic signed [31:0] f_q_r [4];

  logic [31:0] mag_nxt [4];
  logic [65:0] sum_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_nxt[i] = in_q[i][31] ? (32'd0 - in_q[i]) : in_q[i];
    end
    sum_nxt = {2'd0, a_sq_r[0]} + {2'd0, a_sq_r[1]} + {2'd0, a_sq_r[2]} + {2'd0, a_sq_r[3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      nm_v_r <= 1'b0;
      f_v_r  <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_valid;
      b_v_r  <= a_v_r;
      nm_v_r <= sq_v_r[SqSteps-1];
      f_v_r  <= dv_v_r[DvSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a_sg_r[i] <= in_q[i][31];
        a_m_r[i]  <= mag_nxt[i];
        a_sq_r[i] <= mag_nxt[i] * mag_nxt[i];
      end
      b_sg_r   <= a_sg_r;
      b_m_r    <= a_m_r;
      b_zero_r <= (sum_nxt == 66'd0);
      b_s_r    <= (sum_nxt[65:64] != 2'd0) ? {64{1'b1}} : sum_nxt[63:0];
    end
  end

  // square root, two bits of the radicand per stage
  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] n_in, r_in, trial, n_nxt, r_nxt;
    logic [31:0] m_in [4];
    logic        ge;
    if (k == 0) begin : g_first
      assign n_in = b_s_r;
      assign r_in = 64'd0;
      assign m_in = b_m_r;
    end else begin : g_next
      assign n_in = sq_n_r[k-1];
      assign r_in = sq_r_r[k-1];
      assign m_in = sq_m_r[k-1];
    end
    always_comb begin
      trial = r_in + Bit;
      ge    = (n_in >= trial);
      n_nxt = ge ? (n_in - trial) : n_in;
      r_nxt = ge ? ((r_in >> 1) + Bit) : (r_in >> 1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= (k == 0) ? b_v_r : sq_v_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_n_r[k]    <= n_nxt;
        sq_r_r[k]    <= r_nxt;
        sq_m_r[k]    <= m_in;
        sq_sg_r[k]   <= (k == 0) ? b_sg_r : sq_sg_r[(k == 0) ? 0 : k-1];
        sq_zero_r[k] <= (k == 0) ? b_zero_r : sq_zero_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // numerator: magnitude scaled by one, plus half the norm
  logic [31:0] root_n;
  assign root_n = sq_zero_r[SqSteps-1] ? 32'd1 : sq_r_r[SqSteps-1][31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        nm_num_r[i] <= {sq_m_r[SqSteps-1][i], 28'd0} + {29'd0, root_n[31:1]};
      end
      nm_n_r    <= root_n;
      nm_sg_r   <= sq_sg_r[SqSteps-1];
      nm_zero_r <= sq_zero_r[SqSteps-1];
    end
  end

  // restoring divide; the first step only flags a quotient above the clamp
  for (genvar j = 0; j < DvSteps; j++) begin : g_dv
    localparam int B = DvSteps - 1 - j;
    logic [59:0] rem_in  [4];
    logic [28:0] q_in    [4];
    logic [59:0] rem_nxt [4];
    logic [28:0] q_nxt   [4];
    logic [3:0]  sat_in, sat_nxt;
    logic [31:0] n_in;
    logic [61:0] dvs;
    logic        ge [4];
    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          rem_in[i] = nm_num_r[i];
          q_in[i]   = 29'd0;
        end
        sat_in = 4'd0;
        n_in   = nm_n_r;
      end
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          rem_in[i] = dv_rem_r[j-1][i];
          q_in[i]   = dv_q_r[j-1][i];
        end
        sat_in = dv_sat_r[j-1];
        n_in   = dv_n_r[j-1];
      end
    end
    always_comb begin
      dvs = {30'd0, n_in} << B;
      for (int i = 0; i < 4; i++) begin
        ge[i] = ({2'd0, rem_in[i]} >= dvs);
        if (j == 0) begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
          sat_nxt[i] = ge[i];
        end else begin
          rem_nxt[i] = ge[i] ? (rem_in[i] - dvs[59:0]) : rem_in[i];
          q_nxt[i]   = ge[i] ? (q_in[i] | (29'd1 << B)) : q_in[i];
          sat_nxt[i] = sat_in[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= (j == 0) ? nm_v_r : dv_v_r[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j]  <= rem_nxt;
        dv_q_r[j]    <= q_nxt;
        dv_sat_r[j]  <= sat_nxt;
        dv_n_r[j]    <= n_in;
        dv_sg_r[j]   <= (j == 0) ? nm_sg_r : dv_sg_r[(j == 0) ? 0 : j-1];
        dv_zero_r[j] <= (j == 0) ? nm_zero_r : dv_zero_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // clamp to one and restore the sign
  logic [31:0] fmag [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fmag[i] = (dv_sat_r[DvSteps-1][i] || (dv_q_r[DvSteps-1][i] > MagOne)) ?
                {3'd0, MagOne} : {3'd0, dv_q_r[DvSteps-1][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        f_q_r[i] <= dv_sg_r[DvSteps-1][i] ? (32'd0 - fmag[i]) : fmag[i];
      end
      f_zero_r <= dv_zero_r[DvSteps-1];
    end
  end

  assign out_valid = f_v_r;
  assign out_zero  = f_zero_r;
  assign out_q     = f_q_r;

endmodule

FILE: design/rpc_compose.sv
// Seven-stage rotate-and-compose datapath: rotation matrix, position
// transform with saturation, and quaternion product. Depends on rpc_pkg.
module rpc_compose (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] p [4],
  input  logic signed [31:0] l [4],
  input  logic signed [31:0] lp [3],
  input  logic signed [31:0] pp [3],
  output logic               out_valid,
  output logic signed [31:0] pos [3],
  output logic signed [31:0] rot [4]
);

  localparam int Lat = rpc_pkg::COMP_LAT;

  logic v_r [Lat];

  logic signed [63:0] c1_sq_r [9];   // xx yy zz xy xz yz wx wy wz
  logic signed [63:0] c1_qp_r [4][4];
  logic signed [31:0] c1_lp_r [3], c1_pp_r [3];
  logic signed [63:0] c2_m_r [9];
  logic signed [63:0] c2_r_r [4];
  logic signed [31:0] c2_lp_r [3], c2_pp_r [3];
  logic signed [31:0] c3_m_r [9];
  logic signed [31:0] c3_r_r [4];
  logic signed [31:0] c3_lp_r [3], c3_pp_r [3];
  logic signed [63:0] c4_pr_r [9];
  logic signed [31:0] c4_r_r [4], c4_pp_r [3];
  logic signed [63:0] c5_acc_r [3];
  logic signed [31:0] c5_r_r [4], c5_pp_r [3];
  logic signed [39:0] c6_ar_r [3];
  logic signed [31:0] c6_r_r [4], c6_pp_r [3];
  logic signed [31:0] c7_pos_r [3], c7_r_r [4];

  logic signed [63:0] rnd_m [9];
  logic signed [63:0] rnd_r [4];
  logic signed [63:0] rnd_a [3];
  logic signed [40:0] sum_nxt [3];

  always_comb begin
    for (int i = 0; i < 9; i++) rnd_m[i] = rpc_pkg::rnd28(c2_m_r[i]);
    for (int i = 0; i < 4; i++) rnd_r[i] = rpc_pkg::rnd28(c2_r_r[i]);
    for (int i = 0; i < 3; i++) begin
      rnd_a[i]   = rpc_pkg::rnd28(c5_acc_r[i]);
      sum_nxt[i] = {c6_ar_r[i][39], c6_ar_r[i]} + {{9{c6_pp_r[i][31]}}, c6_pp_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < Lat; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // C1: component products
      c1_sq_r[0] <= p[0] * p[0];
      c1_sq_r[1] <= p[1] * p[1];
      c1_sq_r[2] <= p[2] * p[2];
      c1_sq_r[3] <= p[0] * p[1];
      c1_sq_r[4] <= p[0] * p[2];
      c1_sq_r[5] <= p[1] * p[2];
      c1_sq_r[6] <= p[3] * p[0];
      c1_sq_r[7] <= p[3] * p[1];
      c1_sq_r[8] <= p[3] * p[2];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) c1_qp_r[i][j] <= p[i] * l[j];
      end
      c1_lp_r <= lp;
      c1_pp_r <= pp;
      // C2: matrix entries and product sums
      c2_m_r[0] <= rpc_pkg::Q_ONE2 - ((c1_sq_r[1] + c1_sq_r[2]) <<< 1);
      c2_m_r[1] <= (c1_sq_r[3] - c1_sq_r[8]) <<< 1;
      c2_m_r[2] <= (c1_sq_r[4] + c1_sq_r[7]) <<< 1;
      c2_m_r[3] <= (c1_sq_r[3] + c1_sq_r[8]) <<< 1;
      c2_m_r[4] <= rpc_pkg::Q_ONE2 - ((c1_sq_r[0] + c1_sq_r[2]) <<< 1);
      c2_m_r[5] <= (c1_sq_r[5] - c1_sq_r[6]) <<< 1;
      c2_m_r[6] <= (c1_sq_r[4] - c1_sq_r[7]) <<< 1;
      c2_m_r[7] <= (c1_sq_r[5] + c1_sq_r[6]) <<< 1;
      c2_m_r[8] <= rpc_pkg::Q_ONE2 - ((c1_sq_r[0] + c1_sq_r[1]) <<< 1);
      c2_r_r[0] <= c1_qp_r[3][0] + c1_qp_r[0][3] + c1_qp_r[1][2] - c1_qp_r[2][1];
      c2_r_r[1] <= c1_qp_r[3][1] - c1_qp_r[0][2] + c1_qp_r[1][3] + c1_qp_r[2][0];
      c2_r_r[2] <= c1_qp_r[3][2] + c1_qp_r[0][1] - c1_qp_r[1][0] + c1_qp_r[2][3];
      c2_r_r[3] <= c1_qp_r[3][3] - c1_qp_r[0][0] - c1_qp_r[1][1] - c1_qp_r[2][2];
      c2_lp_r <= c1_lp_r;
      c2_pp_r <= c1_pp_r;
      // C3: round to Q.28
      for (int i = 0; i < 9; i++) c3_m_r[i] <= rnd_m[i][31:0];
      for (int i = 0; i < 4; i++) c3_r_r[i] <= rnd_r[i][31:0];
      c3_lp_r <= c2_lp_r;
      c3_pp_r <= c2_pp_r;
      // C4: entry times position
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) c4_pr_r[i*3+j] <= c3_m_r[i*3+j] * c3_lp_r[j];
      end
      c4_r_r  <= c3_r_r;
      c4_pp_r <= c3_pp_r;
      // C5: row sums
      for (int i = 0; i < 3; i++) begin
        c5_acc_r[i] <= c4_pr_r[i*3] + c4_pr_r[i*3+1] + c4_pr_r[i*3+2];
      end
      c5_r_r  <= c4_r_r;
      c5_pp_r <= c4_pp_r;
      // C6: round to Q16.16
      for (int i = 0; i < 3; i++) c6_ar_r[i] <= rnd_a[i][39:0];
      c6_r_r  <= c5_r_r;
      c6_pp_r <= c5_pp_r;
      // C7: add parent position and saturate
      for (int i = 0; i < 3; i++) begin
        if (sum_nxt[i] > 41'sd2147483647) c7_pos_r[i] <= 32'sh7FFF_FFFF;
        else if (sum_nxt[i] < -41'sd2147483648) c7_pos_r[i] <= 32'sh8000_0000;
        else c7_pos_r[i] <= sum_nxt[i][31:0];
      end
      c7_r_r <= c6_r_r;
    end
  end

  assign out_valid = v_r[Lat-1];
  assign pos       = c7_pos_r;
  assign rot       = c7_r_r;

endmodule

FILE: design/rigid_pose_compose_core.sv
// Top level of the rigid pose composition core: parent pose registers,
// normalizers, compose datapath and output skid. Depends on rpc_pkg,
// rpc_delay, rpc_qnorm and rpc_compose.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tdata, 224 bits, local pose
//  out_    | master    | out_tvalid / out_tready| out_tdata, 224 bits, world pose
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index 3 bits, cfg_data 32
//
// One item per cycle sustained while the skid is empty; the square-root and
// divide chains of the normalizers set most of the pipeline depth, one root bit
// or quotient bit a stage.
// Reset clears all valid bits and loads the parent pose to identity.
// A stall freezes the whole pipeline; the skid register takes the one item in
// flight so that in_tready depends only on registered state.
module rigid_pose_compose_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // local_pos_x, local_pos_y, local_pos_z, local_rot_x, local_rot_y,
  // local_rot_z, local_rot_w (32 bits each, lowest first)
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // world_pos_x, world_pos_y, world_pos_z, world_rot_x, world_rot_y,
  // world_rot_z, world_rot_w (32 bits each, lowest first)
  output logic [223:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NormLat = rpc_pkg::NORM_LAT;

  // parent pose registers
  logic [31:0] reg_r [rpc_pkg::NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rpc_pkg::NUM_REGS; i++) reg_r[i] <= 32'd0;
      reg_r[rpc_pkg::REG_ROT_W] <= rpc_pkg::Q_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpc_pkg::REG_POS_X: reg_r[0] <= cfg_data;
        rpc_pkg::REG_POS_Y: reg_r[1] <= cfg_data;
        rpc_pkg::REG_POS_Z: reg_r[2] <= cfg_data;
        rpc_pkg::REG_ROT_X: reg_r[3] <= cfg_data;
        rpc_pkg::REG_ROT_Y: reg_r[4] <= cfg_data;
        rpc_pkg::REG_ROT_Z: reg_r[5] <= cfg_data;
        rpc_pkg::REG_ROT_W: reg_r[6] <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // global advance: the pipeline moves unless the skid holds an item
  logic en;
  logic skid_valid_r;
  assign en        = !skid_valid_r;
  assign in_tready = en;

  logic               acc_in;
  logic signed [31:0] raw_p [4], raw_l [4];
  assign acc_in = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      raw_p[i] = reg_r[3+i];
      raw_l[i] = in_tdata[32*(3+i) +: 32];
    end
  end

  // normalize both quaternions side by side
  logic               np_v, nl_v, np_z, nl_z;
  logic signed [31:0] np_q [4], nl_q [4];

  rpc_qnorm u_norm_p (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc_in), .in_q(raw_p),
    .out_valid(np_v), .out_zero(np_z), .out_q(np_q)
  );

  rpc_qnorm u_norm_l (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(acc_in), .in_q(raw_l),
    .out_valid(nl_v), .out_zero(nl_z), .out_q(nl_q)
  );

  // carry both positions alongside the normalizers
  logic [191:0] pos_in, pos_dly;
  assign pos_in = {reg_r[2], reg_r[1], reg_r[0], in_tdata[95:0]};

  rpc_delay #(.Width(192), .Depth(NormLat)) u_dly_pos (
    .clk(clk), .en(en), .d(pos_in), .q(pos_dly)
  );

  // an all-zero quaternion becomes identity
  logic signed [31:0] pu [4], lu [4], lp [3], pp [3];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pu[i] = np_z ? ((i == 3) ? rpc_pkg::Q_ONE : 32'sd0) : np_q[i];
      lu[i] = nl_z ? ((i == 3) ? rpc_pkg::Q_ONE : 32'sd0) : nl_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      lp[i] = pos_dly[32*i +: 32];
      pp[i] = pos_dly[32*(3+i) +: 32];
    end
  end

  logic               cp_v;
  logic signed [31:0] cp_pos [3], cp_rot [4];

  rpc_compose u_compose (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(np_v && nl_v),
    .p(pu), .l(lu), .lp(lp), .pp(pp),
    .out_valid(cp_v), .pos(cp_pos), .rot(cp_rot)
  );

  // renormalize the product; world position waits beside it
  logic               nr_v, nr_z;
  logic signed [31:0] nr_q [4];

  rpc_qnorm u_norm_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cp_v), .in_q(cp_rot),
    .out_valid(nr_v), .out_zero(nr_z), .out_q(nr_q)
  );

  logic [95:0] wpos_dly;
  rpc_delay #(.Width(96), .Depth(NormLat)) u_dly_wpos (
    .clk(clk), .en(en), .d({cp_pos[2], cp_pos[1], cp_pos[0]}), .q(wpos_dly)
  );

  // a zero product stays zero
  logic [223:0] fin_data;
  always_comb begin
    fin_data[95:0] = wpos_dly;
    for (int i = 0; i < 4; i++) begin
      fin_data[32*(3+i) +: 32] = nr_z ? 32'd0 : nr_q[i];
    end
  end

  // output register plus skid
  logic         out_valid_r;
  logic [223:0] out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipeline frozen; drain the skid once the sink takes the output
      if (out_tready) skid_valid_r <= 1'b0;
    end else if (nr_v) begin
      if (!out_valid_r || out_tready) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) out_data_r <= skid_data_r;
    end else if (nr_v) begin
      if (!out_valid_r || out_tready) out_data_r <= fin_data;
      else skid_data_r <= fin_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
